// File: src/pabt_pkg.sv
`default_nettype none

package pabt_pkg;

  // fixed field widths of the request and response beats
  localparam int ADDR_W    = 64;
  localparam int LEN_W     = 4;
  localparam int LINK_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int IDX_OUT_W = 4;

  // default table geometry
  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int DEF_ADDR_BYTES    = 8;

  typedef enum logic {
    REQ_FIND = 1'b0,
    REQ_BIND = 1'b1
  } pabt_req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_ARG_ERR  = 2'd1,
    STAT_CONFLICT = 2'd2,
    STAT_NO_SPACE = 2'd3
  } pabt_status_t;

  // per-cycle control into the scan unit
  typedef struct packed {
    logic clear;  // start of a new request
    logic vld;    // compare stage holds an entry
    logic occ;    // that entry is occupied
  } pabt_scan_ctl_t;

  // accumulated scan outcome
  typedef struct packed {
    logic have_match;
    logic have_free;
  } pabt_scan_res_t;

endpackage

`default_nettype wire

// File: src/pabt_ram.sv
`default_nettype none

module pabt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/pabt_scan.sv
`default_nettype none

module pabt_scan
  import pabt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ADDR_BYTES    = DEF_ADDR_BYTES,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int SA_W  = ADDR_BYTES * 8,
  localparam int ENT_W = SA_W + LEN_W + LINK_W
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pabt_scan_ctl_t ctl,
  input  wire logic [IDX_W-1:0]  ent_idx,
  input  wire logic [ENT_W-1:0]  ent_data,
  input  wire logic [SA_W-1:0]   req_addr,
  input  wire logic [LEN_W-1:0]  req_len,
  output pabt_scan_res_t      res,
  output logic [IDX_W-1:0]    match_idx,
  output logic [LINK_W-1:0]   match_link,
  output logic [IDX_W-1:0]    free_idx
);

  logic              have_match_r;
  logic              have_free_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic [LINK_W-1:0] match_link_r;
  logic [IDX_W-1:0]  free_idx_r;

  logic [SA_W-1:0]   ent_addr;
  logic [LEN_W-1:0]  ent_len;
  logic [LINK_W-1:0] ent_link;
  logic              hit;
  logic              take_match;
  logic              take_free;

  assign ent_addr = ent_data[ENT_W-1 -: SA_W];
  assign ent_len  = ent_data[LINK_W +: LEN_W];
  assign ent_link = ent_data[LINK_W-1:0];

  // the one shared comparator: length and masked address
  assign hit        = (ent_len == req_len) && (ent_addr == req_addr);
  assign take_match = ctl.vld && ctl.occ && !have_match_r && hit;
  assign take_free  = ctl.vld && !ctl.occ && !have_free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_match_r <= 1'b0;
      have_free_r  <= 1'b0;
    end else if (ctl.clear) begin
      have_match_r <= 1'b0;
      have_free_r  <= 1'b0;
    end else begin
      if (take_match) begin
        have_match_r <= 1'b1;
      end
      if (take_free) begin
        have_free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_match) begin
      match_idx_r  <= ent_idx;
      match_link_r <= ent_link;
    end
    if (take_free) begin
      free_idx_r <= ent_idx;
    end
  end

  assign res.have_match = have_match_r;
  assign res.have_free  = have_free_r;
  assign match_idx      = match_idx_r;
  assign match_link     = match_link_r;
  assign free_idx       = free_idx_r;

endmodule

`default_nettype wire

// File: src/peer_address_binding_table.sv
// a find or bind with valid arguments is answered after a scan over every entry; a rejected
//   request (bad length or bind to link 0) skips the scan and is answered directly
// one request at a time, set by the single compare unit that walks the entry RAM one slot
//   per cycle; a new request is taken only once the previous response has been registered
// reset: synchronous active-low rst_n empties the table (occupied flags cleared at once)
//   and drops out_valid; no clearing pass, first request can follow immediately
`default_nettype none

module peer_address_binding_table
  import pabt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ADDR_BYTES    = DEF_ADDR_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_req_type,
  input  wire logic [ADDR_W-1:0]     in_addr_bytes,
  input  wire logic [LEN_W-1:0]      in_addr_length,
  input  wire logic [LINK_W-1:0]     in_link_id,
  // response channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic                       out_found,
  output logic [IDX_OUT_W-1:0]       out_entry_index,
  output logic [LINK_W-1:0]          out_entry_link
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SA_W  = ADDR_BYTES * 8;
  localparam int ENT_W = SA_W + LEN_W + LINK_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(ADDR_BYTES);

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_DRAIN   = 5'b00100,
    S_RESOLVE = 5'b01000,
    S_SPARE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // latched request
  logic              req_bind_r;
  logic [SA_W-1:0]   req_addr_r;
  logic [LEN_W-1:0]  req_len_r;
  logic [LINK_W-1:0] req_link_r;
  logic              args_ok_r;

  // scan pointer and compare-stage tags
  logic [IDX_W-1:0]  iss_r;
  logic              cmp_vld_r;
  logic              cmp_occ_r;
  logic [IDX_W-1:0]  cmp_idx_r;

  // occupied flags, one flop per slot
  logic [TABLE_ENTRIES-1:0] occ_r;

  // response register
  logic                 out_valid_r;
  pabt_status_t         out_status_r;
  logic                 out_found_r;
  logic [IDX_OUT_W-1:0] out_index_r;
  logic [LINK_W-1:0]    out_link_r;

  logic              accept;
  logic              in_args_ok;
  logic [SA_W-1:0]   in_addr_masked;
  logic              res_go;
  logic              do_write;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;

  pabt_scan_ctl_t    scan_ctl;
  pabt_scan_res_t    scan_res;
  logic [IDX_W-1:0]  match_idx;
  logic [LINK_W-1:0] match_link;
  logic [IDX_W-1:0]  free_idx;

  pabt_status_t         res_status;
  logic                 res_found;
  logic [IDX_W-1:0]     res_idx;
  logic [LINK_W-1:0]    res_link;
  logic [IDX_W+IDX_OUT_W-1:0] res_idx_ext;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // argument check: length in 1..ADDR_BYTES, and a bind needs a nonzero link
  assign in_args_ok = (in_addr_length != '0) && (in_addr_length <= MAX_LEN) &&
                      !((in_req_type == REQ_BIND) && (in_link_id == '0));

  // zero the bytes past the length so stored addresses compare directly
  always_comb begin
    for (int b = 0; b < ADDR_BYTES; b++) begin
      in_addr_masked[b*8 +: 8] = (LEN_W'(b) < in_addr_length) ?
                                 in_addr_bytes[b*8 +: 8] : 8'h00;
    end
  end

  // response can be loaded once the response register is free or draining
  assign res_go = (state_r == S_RESOLVE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = in_args_ok ? S_SCAN : S_RESOLVE;
        end
      end
      S_SCAN: begin
        if (iss_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (res_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      req_bind_r <= (in_req_type == REQ_BIND);
      req_addr_r <= in_addr_masked;
      req_len_r  <= in_addr_length;
      req_link_r <= in_link_id;
      args_ok_r  <= in_args_ok;
    end
  end

  // scan pointer: issues one RAM read per cycle, compare follows in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= (state_r == S_SCAN);
      if (accept) begin
        iss_r <= '0;
      end else if (state_r == S_SCAN && iss_r != LAST_IDX) begin
        iss_r <= iss_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= iss_r;
    cmp_occ_r <= occ_r[iss_r];
  end

  assign scan_ctl.clear = accept;
  assign scan_ctl.vld   = cmp_vld_r;
  assign scan_ctl.occ   = cmp_occ_r;

  pabt_scan #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ADDR_BYTES   (ADDR_BYTES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .ent_idx   (cmp_idx_r),
    .ent_data  (ram_rdata),
    .req_addr  (req_addr_r),
    .req_len   (req_len_r),
    .res       (scan_res),
    .match_idx (match_idx),
    .match_link(match_link),
    .free_idx  (free_idx)
  );

  // resolve the outcome of the finished scan
  always_comb begin
    res_status = STAT_OK;
    res_found  = 1'b0;
    res_idx    = '0;
    res_link   = '0;
    do_write   = 1'b0;
    if (!args_ok_r) begin
      res_status = req_bind_r ? STAT_ARG_ERR : STAT_OK;
    end else if (scan_res.have_match) begin
      res_found = 1'b1;
      res_idx   = match_idx;
      res_link  = match_link;
      if (req_bind_r && (match_link != req_link_r)) begin
        res_status = STAT_CONFLICT;
      end
    end else if (req_bind_r) begin
      if (scan_res.have_free) begin
        // new binding goes into the lowest free slot
        res_idx  = free_idx;
        res_link = req_link_r;
        do_write = res_go;
      end else begin
        res_status = STAT_NO_SPACE;
      end
    end
  end

  // entry index is reported as the low bits of the slot number
  assign res_idx_ext = {{IDX_OUT_W{1'b0}}, res_idx};

  assign ram_wdata = {req_addr_r, req_len_r, req_link_r};

  pabt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (do_write),
    .waddr(free_idx),
    .wdata(ram_wdata),
    .raddr(iss_r),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (do_write) begin
      occ_r[free_idx] <= 1'b1;
    end
  end

  // response register parts the sequencer from the downstream side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_go) begin
      out_status_r <= res_status;
      out_found_r  <= res_found;
      out_index_r  <= res_idx_ext[IDX_OUT_W-1:0];
      out_link_r   <= res_link;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_entry_index = out_index_r;
  assign out_entry_link  = out_link_r;

endmodule

`default_nettype wire

// File: src/pabt_checker.sv
`default_nettype none

module pabt_checker
  import pabt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [STATUS_W-1:0]   out_status,
  input wire logic                  out_found,
  input wire logic [IDX_OUT_W-1:0]  out_entry_index,
  input wire logic [LINK_W-1:0]     out_entry_link
);

  // a stalled response beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_found) &&
    $stable(out_entry_index) && $stable(out_entry_link))
    else $error("response changed while stalled");

  // a request is worked on alone
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a rejected bind carries no entry
  a_arg_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_ARG_ERR |->
    !out_found && out_entry_index == '0 && out_entry_link == '0)
    else $error("argument error with entry data");

  // a full table carries no entry
  a_no_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_NO_SPACE |->
    !out_found && out_entry_index == '0 && out_entry_link == '0)
    else $error("no-space with entry data");

  // a conflict always names the existing binding
  a_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_CONFLICT |-> out_found && out_entry_link != '0)
    else $error("conflict without a found entry");

endmodule

bind peer_address_binding_table pabt_checker u_pabt_checker (.*);

`default_nettype wire

// File: dv/peer_address_binding_table_tb.sv
`timescale 1ns / 100ps

module peer_address_binding_table_tb;
  import pabt_pkg::*;

  localparam int SLOTS       = DEF_TABLE_ENTRIES;
  localparam int MAX_LEN     = DEF_ADDR_BYTES;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int MAX_REPORTS = 40;

  // one expected response beat
  typedef struct {
    pabt_status_t         status;
    logic                 found;
    logic [IDX_OUT_W-1:0] index;
    logic [LINK_W-1:0]    link;
  } lookup_resp_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_req_type;
  logic [ADDR_W-1:0]    in_addr_bytes;
  logic [LEN_W-1:0]     in_addr_length;
  logic [LINK_W-1:0]    in_link_id;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_found;
  logic [IDX_OUT_W-1:0] out_entry_index;
  logic [LINK_W-1:0]    out_entry_link;

  // shadow copy of the binding table
  logic                 shadow_occ  [SLOTS];
  logic [ADDR_W-1:0]    shadow_addr [SLOTS];
  logic [LEN_W-1:0]     shadow_len  [SLOTS];
  logic [LINK_W-1:0]    shadow_link [SLOTS];
  int                   bound_count;

  lookup_resp_t         pending_resp[$];
  int                   error_count;
  int                   cycle_count;

  // idle rates in percent, and a long receiver hold-off
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   recv_hold_left;

  peer_address_binding_table #(
    .TABLE_ENTRIES(SLOTS),
    .ADDR_BYTES   (MAX_LEN)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_addr_bytes  (in_addr_bytes),
    .in_addr_length (in_addr_length),
    .in_link_id     (in_link_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_entry_index(out_entry_index),
    .out_entry_link (out_entry_link)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // keeps the bytes inside the length, drops the rest
  function automatic logic [ADDR_W-1:0] length_mask(logic [LEN_W-1:0] len);
    if (len >= 8)
      return '1;
    return (64'h1 << (8 * len)) - 64'h1;
  endfunction

  // expected response for one request, updates the shadow table on a new binding
  function automatic lookup_resp_t predict_lookup(pabt_req_t req, logic [ADDR_W-1:0] bytes,
                                                  logic [LEN_W-1:0] len,
                                                  logic [LINK_W-1:0] link);
    lookup_resp_t     r;
    logic [ADDR_W-1:0] key;
    bit               hit;
    bit               has_free;
    int               hit_slot;
    int               open_slot;
    r = '{STAT_OK, 1'b0, '0, '0};
    key = bytes & length_mask(len);
    hit = 0;
    has_free = 0;
    hit_slot = 0;
    open_slot = 0;
    // bad length or bind to no link: rejected, table untouched
    if (len == 0 || len > MAX_LEN || (req == REQ_BIND && link == '0)) begin
      if (req == REQ_BIND)
        r.status = STAT_ARG_ERR;
      return r;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_occ[i]) begin
        if (!hit && shadow_len[i] == len && shadow_addr[i] == key) begin
          hit = 1;
          hit_slot = i;
        end
      end else if (!has_free) begin
        has_free = 1;
        open_slot = i;
      end
    end
    if (hit) begin
      r.found = 1'b1;
      r.index = hit_slot[IDX_OUT_W-1:0];
      r.link  = shadow_link[hit_slot];
      if (req == REQ_BIND && shadow_link[hit_slot] != link)
        r.status = STAT_CONFLICT;
    end else if (req == REQ_BIND) begin
      if (has_free) begin
        // new address goes to the lowest free slot
        shadow_occ[open_slot]  = 1'b1;
        shadow_addr[open_slot] = key;
        shadow_len[open_slot]  = len;
        shadow_link[open_slot] = link;
        bound_count++;
        r.index = open_slot[IDX_OUT_W-1:0];
        r.link  = link;
      end else begin
        r.status = STAT_NO_SPACE;
      end
    end
    return r;
  endfunction

  // offers one request beat, predicts its response once it is taken
  task automatic send_request(pabt_req_t req, logic [ADDR_W-1:0] bytes,
                              logic [LEN_W-1:0] len, logic [LINK_W-1:0] link);
    // random gap in front of the beat
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_addr_bytes  <= bytes;
    in_addr_length <= len;
    in_link_id     <= link;
    do
      @(posedge clk);
    while (!in_ready);
    pending_resp.push_back(predict_lookup(req, bytes, len, link));
  endtask

  // sender stops and waits until every response is back
  task automatic wait_all_responses();
    in_valid <= 1'b0;
    while (pending_resp.size() != 0)
      @(posedge clk);
  endtask

  // result receiver: random stalls, or a long hold-off when one is asked
  always @(posedge clk) begin
    if (recv_hold_left > 0) begin
      out_ready <= 1'b0;
      recv_hold_left = recv_hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // response checker
  always @(posedge clk) begin
    lookup_resp_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_resp.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: response beat with nothing expected, status %0d index %0d",
                   $time, out_status, out_entry_index);
      end else begin
        exp_r = pending_resp.pop_front();
        if (out_status !== exp_r.status) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, exp_r.status, out_status);
        end
        if (out_found !== exp_r.found) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: found mismatch, expected %0d, actual %0d",
                     $time, exp_r.found, out_found);
        end
        if (out_entry_index !== exp_r.index) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: entry_index mismatch, expected %0d, actual %0d",
                     $time, exp_r.index, out_entry_index);
        end
        if (out_entry_link !== exp_r.link) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: entry_link mismatch, expected %0d, actual %0d",
                     $time, exp_r.link, out_entry_link);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // argument checks, first bindings, same-link rebind, conflict, length rules
  task automatic test_basic_requests();
    send_idle_pct = 28;
    recv_idle_pct = 70;
    // find on an empty table, then bad lengths
    send_request(REQ_FIND, 64'h0, 4'd1, 8'd0);
    send_request(REQ_FIND, 64'hDEAD_BEEF_0123_4567, 4'd0, 8'd9);
    send_request(REQ_FIND, 64'h0, 4'd9, 8'd0);
    send_request(REQ_BIND, 64'h1111_2222_3333_4444, 4'd0, 8'd5);
    send_request(REQ_BIND, 64'h1111_2222_3333_4444, 4'd9, 8'd5);
    send_request(REQ_BIND, '1, 4'd15, 8'd255);
    // bind to link zero is rejected
    send_request(REQ_BIND, 64'h0000_0000_00AB_CDEF, 4'd3, 8'd0);
    // all-ones address at full length goes to slot 0
    send_request(REQ_BIND, '1, 4'd8, 8'd255);
    // one-byte address, upper bytes are junk and must be ignored
    send_request(REQ_BIND, 64'hFFFF_FFFF_FFFF_FF00, 4'd1, 8'd1);
    send_request(REQ_BIND, 64'h1234_5678_9ABC_DE00, 4'd1, 8'd1);
    // same address, other link: conflict reports the stored link
    send_request(REQ_BIND, 64'h0, 4'd1, 8'd7);
    // same low byte at another length is a different address
    send_request(REQ_FIND, 64'h0, 4'd2, 8'd0);
    send_request(REQ_BIND, 64'hAB00_0000_0000_0000, 4'd2, 8'd2);
    send_request(REQ_FIND, '1, 4'd8, 8'd0);
    send_request(REQ_BIND, 64'h0, 4'd8, 8'd128);
    wait_all_responses();
  endtask

  // fill every slot with random addresses, then a bind that finds no room
  task automatic test_table_full();
    logic [ADDR_W-1:0] bytes;
    send_idle_pct = 28;
    recv_idle_pct = 70;
    while (bound_count < SLOTS) begin
      bytes = {$urandom, $urandom};
      send_request(REQ_BIND, bytes, LEN_W'($urandom_range(1, MAX_LEN)),
                   LINK_W'($urandom_range(1, 255)));
    end
    bytes = {$urandom, $urandom};
    send_request(REQ_BIND, bytes, 4'd8, 8'd77);
    send_request(REQ_FIND, shadow_addr[SLOTS-1], shadow_len[SLOTS-1], 8'd0);
    wait_all_responses();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering beats
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_left = 400;
    for (int i = 0; i < 10; i++)
      send_request(pabt_req_t'(i % 2), shadow_addr[i], shadow_len[i], shadow_link[i]);
    wait_all_responses();
  endtask

  // random traffic, mostly near the bound addresses so that lookups hit and miss
  task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
    pabt_req_t         req;
    logic [ADDR_W-1:0] bytes;
    logic [LEN_W-1:0]  len;
    logic [LINK_W-1:0] link;
    int                slot;
    int                pick;
    int                b;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < n_items; n++) begin
      req  = pabt_req_t'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // noise: any length, any bytes, any link
        bytes = {$urandom, $urandom};
        len   = LEN_W'($urandom_range(0, 15));
        link  = LINK_W'($urandom_range(0, 255));
      end else begin
        slot  = $urandom_range(0, SLOTS - 1);
        len   = shadow_len[slot];
        bytes = shadow_addr[slot];
        if (pick < 45) begin
          // near miss: another length
          len = LEN_W'($urandom_range(1, MAX_LEN));
        end else if (pick < 60) begin
          // near miss: one byte inside the length changed
          b = $urandom_range(0, len - 1);
          bytes = bytes ^ (64'($urandom_range(1, 255)) << (8 * b));
        end
        // junk above the length
        bytes = (bytes & length_mask(len)) | ({$urandom, $urandom} & ~length_mask(len));
        b = $urandom_range(0, 9);
        if (b < 5)
          link = shadow_link[slot];
        else if (b < 9)
          link = LINK_W'($urandom_range(1, 255));
        else
          link = '0;
      end
      send_request(req, bytes, len, link);
    end
    wait_all_responses();
  endtask

  initial begin
    in_valid       = 1'b0;
    in_req_type    = 1'b0;
    in_addr_bytes  = '0;
    in_addr_length = '0;
    in_link_id     = '0;
    out_ready      = 1'b0;
    rst_n          = 1'b0;
    error_count    = 0;
    cycle_count    = 0;
    bound_count    = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    recv_hold_left = 0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_occ[i]  = 1'b0;
      shadow_addr[i] = '0;
      shadow_len[i]  = '0;
      shadow_link[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_requests();
    test_table_full();
    test_backpressure();
    test_random_traffic(300, 28, 70);
    test_random_traffic(300, 70, 28);
    test_random_traffic(300, 0, 0);

    // allow a full scan for anything unexpected to show up
    repeat (SLOTS + 8) @(posedge clk);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
